// ===== rtl/spq_pkg.sv =====
package spq_pkg;

  // default number of queue slots
  localparam int unsigned CAPACITY = 16;

  // request codes
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // status codes
  localparam logic [1:0] ST_PUSHED = 2'd0;
  localparam logic [1:0] ST_POPPED = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic        req_type;
    logic [31:0] time_left;
    logic [31:0] proc_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_time_left;
    logic [31:0] out_proc_id;
    logic [4:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0] time_left;
    logic [31:0] proc_id;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic   shift_in;
    logic   shift_out;
    entry_t ins;
  } cell_ctl_t;

  // true when a sorts strictly ahead of b
  function automatic logic ahead_of(entry_t a, entry_t b);
    logic res;
    if (a.time_left != b.time_left) begin
      res = a.time_left < b.time_left;
    end else begin
      res = a.proc_id < b.proc_id;
    end
    return res;
  endfunction

endpackage

// ===== rtl/spq_cell.sv =====
module spq_cell (
  input  logic              clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic              valid,
  input  logic              left_go,
  input  spq_pkg::entry_t   left_entry,
  input  spq_pkg::entry_t   right_entry,
  output spq_pkg::entry_t   entry,
  output logic              go
);

  // this slot stays put on a push when it sorts ahead of the new entry
  assign go = valid && spq_pkg::ahead_of(entry, ctl.ins);

  // pop shifts toward the front, push opens a gap at the insert point
  always_ff @(posedge clk) begin
    if (ctl.shift_out) begin
      entry <= right_entry;
    end else if (ctl.shift_in && !go) begin
      entry <= left_go ? ctl.ins : left_entry;
    end
  end

endmodule

// ===== rtl/sorted_priority_queue_unit.sv =====
// Sorted insertion priority queue built as a row of compare-and-shift cells.
// A transaction is captured in the request register, and its result and the result
// strobe (done) are then registered from it in the result register.
// Throughput: one push or pop per cycle; busy stays low, since every cell
// updates straight from the request register.
// Reset (synchronous, active high) empties the queue; slot contents are not cleared.
module sorted_priority_queue_unit #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  spq_pkg::req_t req,
  output logic          done,
  output spq_pkg::rsp_t rsp
);

  localparam int unsigned HW = $clog2(CAPACITY + 1);

  logic                 pending;
  spq_pkg::req_t        req_q;
  logic [HW-1:0]        held;
  logic [HW-1:0]        held_next;
  logic                 push_ok;
  logic                 pop_ok;
  logic                 is_push;
  spq_pkg::cell_ctl_t   ctl;
  spq_pkg::entry_t      cell_entry [CAPACITY];
  logic                 cell_go    [CAPACITY];
  logic [HW+4:0]        count_wide;
  logic [1:0]           status_next;

  // every cell updates straight from the request register, so a new transaction is always welcome
  assign busy = 1'b0;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else begin
      pending <= start && !busy;
    end
    if (start && !busy) begin
      req_q <= req;
    end
  end

  // decode the registered request against the fill count
  assign is_push = req_q.req_type == spq_pkg::REQ_PUSH;
  assign push_ok = pending && is_push && (held != HW'(CAPACITY));
  assign pop_ok  = pending && !is_push && (held != '0);

  always_comb begin
    held_next = held;
    if (push_ok) begin
      held_next = held + HW'(1);
    end else if (pop_ok) begin
      held_next = held - HW'(1);
    end
  end

  always_comb begin
    if (is_push) begin
      status_next = push_ok ? spq_pkg::ST_PUSHED : spq_pkg::ST_FULL;
    end else begin
      status_next = pop_ok ? spq_pkg::ST_POPPED : spq_pkg::ST_EMPTY;
    end
  end

  assign ctl.shift_in      = push_ok;
  assign ctl.shift_out     = pop_ok;
  assign ctl.ins.time_left = req_q.time_left;
  assign ctl.ins.proc_id   = req_q.proc_id;

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::entry_t left_e;
    spq_pkg::entry_t right_e;
    logic            left_g;

    if (i == 0) begin : g_head
      assign left_e = ctl.ins;
      assign left_g = 1'b1;
    end else begin : g_body
      assign left_e = cell_entry[i-1];
      assign left_g = cell_go[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_e = cell_entry[i];
    end else begin : g_mid
      assign right_e = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .valid       (held > HW'(i)),
      .left_go     (left_g),
      .left_entry  (left_e),
      .right_entry (right_e),
      .entry       (cell_entry[i]),
      .go          (cell_go[i])
    );
  end

  assign count_wide = {5'd0, held_next};

  // fill count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
      done <= 1'b0;
    end else begin
      held <= held_next;
      done <= pending;
    end
    if (pending) begin
      rsp.status        <= status_next;
      rsp.out_time_left <= pop_ok ? cell_entry[0].time_left : 32'd0;
      rsp.out_proc_id   <= pop_ok ? cell_entry[0].proc_id : 32'd0;
      rsp.entry_count   <= count_wide[4:0];
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned RANDOM_ITEMS = 1350;
  localparam int unsigned PHASE_LEN = 60;
  localparam int unsigned DRAIN_CYCLES = 4;

  // one row of the directed plan
  typedef struct {
    spq_pkg::req_t r;
    bit            typed;
    spq_pkg::rsp_t want;
  } plan_row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  spq_pkg::req_t req;
  logic done;
  spq_pkg::rsp_t rsp;

  // predictor state: sorted slots and count held
  spq_pkg::entry_t slot_q[spq_pkg::CAPACITY];
  int unsigned held_cnt;

  spq_pkg::rsp_t expected_rsp[$];
  plan_row_t plan[$];

  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned burst_left;
  int unsigned n_push, n_pop, n_empty, n_full;

  sorted_priority_queue_unit u_top (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // sorted insert on push, take the head on pop
  function automatic spq_pkg::rsp_t apply_request(spq_pkg::req_t r);
    spq_pkg::rsp_t res;
    spq_pkg::entry_t e;
    int unsigned pos;
    int unsigned i;
    res = '0;
    if (r.req_type == spq_pkg::REQ_PUSH) begin
      if (held_cnt >= spq_pkg::CAPACITY) begin
        res.status = spq_pkg::ST_FULL;
        n_full++;
      end else begin
        e.time_left = r.time_left;
        e.proc_id   = r.proc_id;
        pos = 0;
        // skip held entries that sort strictly ahead of the new one
        while (pos < held_cnt &&
               (slot_q[pos].time_left < e.time_left ||
                (slot_q[pos].time_left == e.time_left && slot_q[pos].proc_id < e.proc_id)))
          pos++;
        for (i = held_cnt; i > pos; i--) slot_q[i] = slot_q[i-1];
        slot_q[pos] = e;
        held_cnt++;
        res.status = spq_pkg::ST_PUSHED;
        n_push++;
      end
    end else begin
      if (held_cnt == 0) begin
        res.status = spq_pkg::ST_EMPTY;
        n_empty++;
      end else begin
        res.out_time_left = slot_q[0].time_left;
        res.out_proc_id   = slot_q[0].proc_id;
        for (i = 1; i < held_cnt; i++) slot_q[i-1] = slot_q[i];
        held_cnt--;
        res.status = spq_pkg::ST_POPPED;
        n_pop++;
      end
    end
    res.entry_count = held_cnt[4:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    err_cnt++;
  endtask

  task automatic add_row(logic rt, logic [31:0] tl, logic [31:0] id, bit typed,
                         logic [1:0] st, logic [31:0] ot, logic [31:0] oi,
                         logic [4:0] cnt);
    plan_row_t row;
    row.r.req_type          = rt;
    row.r.time_left         = tl;
    row.r.proc_id           = id;
    row.typed               = typed;
    row.want.status         = st;
    row.want.out_time_left  = ot;
    row.want.out_proc_id    = oi;
    row.want.entry_count    = cnt;
    plan.push_back(row);
  endtask

  // hold start until the block takes the transaction, then log its expectation
  task automatic send_request(spq_pkg::req_t r, bit typed, spq_pkg::rsp_t want);
    spq_pkg::rsp_t pred;
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = apply_request(r);
    expected_rsp.push_back(typed ? want : pred);
  endtask

  // bursts of back-to-back requests separated by random gaps
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
  endtask

  // keys biased toward ties and extremes
  function automatic logic [31:0] pick_key();
    logic [31:0] k;
    case ($urandom_range(0, 5))
      0:       k = 32'h0;
      1:       k = 32'hFFFF_FFFF;
      2, 3:    k = $urandom_range(0, 7);
      default: k = $urandom();
    endcase
    return k;
  endfunction

  // result checker: every strobe must match the oldest expectation
  always @(posedge clk) begin
    spq_pkg::rsp_t want;
    if (!rst && done) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch("result with no transaction pending", 32'd0, 32'(rsp.status));
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(rsp.status));
        if (rsp.out_time_left !== want.out_time_left)
          report_mismatch("out_time_left", want.out_time_left, rsp.out_time_left);
        if (rsp.out_proc_id !== want.out_proc_id)
          report_mismatch("out_proc_id", want.out_proc_id, rsp.out_proc_id);
        if (rsp.entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(want.entry_count), 32'(rsp.entry_count));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, expected_rsp.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    spq_pkg::req_t r;
    spq_pkg::rsp_t none;
    int unsigned push_pct;
    int unsigned n;
    rst        = 1'b1;
    start      = 1'b0;
    req        = '0;
    held_cnt   = 0;
    err_cnt    = 0;
    cycle_cnt  = 0;
    burst_left = 0;
    n_push     = 0;
    n_pop      = 0;
    n_empty    = 0;
    n_full     = 0;
    none       = '0;

    // directed plan
    add_row(spq_pkg::REQ_POP, 32'h0, 32'h0, 1'b1,
            spq_pkg::ST_EMPTY, 32'h0, 32'h0, 5'd0);
    add_row(spq_pkg::REQ_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
            spq_pkg::ST_PUSHED, 32'h0, 32'h0, 5'd1);
    add_row(spq_pkg::REQ_PUSH, 32'h0, 32'h0, 1'b1,
            spq_pkg::ST_PUSHED, 32'h0, 32'h0, 5'd2);
    add_row(spq_pkg::REQ_PUSH, 32'd5, 32'd9, 1'b0,
            spq_pkg::ST_PUSHED, 32'h0, 32'h0, 5'd0);
    // equal time, lower id goes first
    add_row(spq_pkg::REQ_PUSH, 32'd5, 32'd3, 1'b0,
            spq_pkg::ST_PUSHED, 32'h0, 32'h0, 5'd0);
    // identical entry
    add_row(spq_pkg::REQ_PUSH, 32'd5, 32'd3, 1'b0,
            spq_pkg::ST_PUSHED, 32'h0, 32'h0, 5'd0);
    add_row(spq_pkg::REQ_POP, 32'h0, 32'h0, 1'b1,
            spq_pkg::ST_POPPED, 32'h0, 32'h0, 5'd4);
    // fill to capacity
    for (n = 0; n < spq_pkg::CAPACITY - 4; n++)
      add_row(spq_pkg::REQ_PUSH, 32'd100 + n * 3, n, 1'b0,
              spq_pkg::ST_PUSHED, 32'h0, 32'h0, 5'd0);
    add_row(spq_pkg::REQ_PUSH, 32'd1, 32'd1, 1'b1,
            spq_pkg::ST_FULL, 32'h0, 32'h0, 5'd16);
    add_row(spq_pkg::REQ_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
            spq_pkg::ST_POPPED, 32'd5, 32'd3, 5'd15);
    add_row(spq_pkg::REQ_POP, 32'h0, 32'h0, 1'b0,
            spq_pkg::ST_POPPED, 32'h0, 32'h0, 5'd0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      pace_sender();
      send_request(plan[k].r, plan[k].typed, plan[k].want);
    end
    wait_drained();

    // random part in phases of differing push/pop mix
    push_pct = 50;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        case ($urandom_range(0, 4))
          0:       push_pct = 15;
          1:       push_pct = 85;
          2:       push_pct = 100;
          default: push_pct = 50;
        endcase
        if ((n / PHASE_LEN) % 5 == 4) wait_drained();
      end
      r.req_type  = ($urandom_range(0, 99) < push_pct) ? spq_pkg::REQ_PUSH : spq_pkg::REQ_POP;
      r.time_left = pick_key();
      r.proc_id   = pick_key();
      pace_sender();
      send_request(r, 1'b0, none);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d pushes, %0d pops, %0d pops on empty, %0d pushes on full",
             n_push, n_pop, n_empty, n_full);
    $display("in %0d cycles with %0d mismatches", cycle_cnt, err_cnt);
    if (err_cnt == 0 && expected_rsp.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
